[src/range_max_query_table_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the range maximum table
// Concurrent assertion wrappers that compile away when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef RANGE_MAX_QUERY_TABLE_MACROS_SVH
`define RANGE_MAX_QUERY_TABLE_MACROS_SVH

`ifndef ASSERT_OFF

// Property that must hold at every edge outside reset.
`define RMQ_ASSERT(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) \
    else $error("range_max_query_table assertion failed");

// Consequent that must hold in the cycle after the antecedent.
`define RMQ_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("range_max_query_table assertion failed");

`else

`define RMQ_ASSERT(lbl, ck, rs, prop)
`define RMQ_ASSERT_NEXT(lbl, ck, rs, ante, cons)

`endif

`endif

[src/rmq_pkg.sv]
// ---------------------------------------------------------------------------
// rmq_pkg
// Shared constants, codes and types of the range maximum table.
// ---------------------------------------------------------------------------
package rmq_pkg;

  localparam int POS_W           = 11;
  localparam int VAL_W           = 32;
  localparam int CFG_W           = 11;
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int IN_DATA_W       = 72;
  localparam int OUT_DATA_W      = 40;

  localparam logic [CFG_W-1:0]        ENTRIES_RESET = 11'd1024;
  localparam logic signed [VAL_W-1:0] MAX_FLOOR     = -32'sd20000;

  // Item kinds carried on the input tuser.
  localparam logic ACT_UPDATE = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } rmq_state_t;

  // Command handed to the engine on an accepted input beat.
  typedef struct packed {
    logic valid;
    logic update;     // in-range update: write the entry
    logic query;      // any query
    logic bad_bound;  // query bound outside the entries in use
    logic empty;      // query with start above end
  } rmq_cmd_t;

  typedef struct packed {
    logic valid;
    logic range_error;
  } rmq_res_t;

  // True when a 1-based bound lies within 1 .. lim.
  function automatic logic bound_ok(logic [POS_W-1:0] b, logic [CFG_W-1:0] lim);
    return (b != '0) && (b <= lim);
  endfunction

endpackage

[src/rmq_engine.sv]
// ---------------------------------------------------------------------------
// rmq_engine
// Table memory with its clearing pass, update writes and the range scan.
// ---------------------------------------------------------------------------
`include "range_max_query_table_macros.svh"

module rmq_engine #(
  parameter int TABLE_DEPTH = rmq_pkg::TABLE_DEPTH_DEF,
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  rmq_pkg::rmq_cmd_t         cmd,
  input  logic [AW-1:0]             wr_addr,
  input  logic [rmq_pkg::VAL_W-1:0] wr_data,
  input  logic [AW-1:0]             start_addr,
  input  logic [AW-1:0]             end_addr,
  output logic                      ready,
  output rmq_pkg::rmq_res_t         res,
  output logic [rmq_pkg::VAL_W-1:0] res_max,
  input  logic                      res_ready
);

  import rmq_pkg::*;

  localparam logic [AW-1:0] CLR_LAST = AW'(TABLE_DEPTH - 1);

  logic [VAL_W-1:0] mem [TABLE_DEPTH];

  rmq_state_t              state, state_next;
  logic [AW-1:0]           clr;
  logic [AW-1:0]           cur;
  logic [AW-1:0]           end_q;
  logic signed [VAL_W-1:0] best;
  logic signed [VAL_W-1:0] rd_data;
  logic                    err;

  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic [VAL_W-1:0] mem_wd;
  logic [AW-1:0]    rd_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr <= clr + AW'(1);
      end
    end
  end

  always_comb begin
    state_next  = state;
    ready       = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = clr;
    mem_wd      = '0;
    rd_addr     = cur + AW'(1);
    res.valid   = 1'b0;
    res.range_error = err;
    unique case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr == CLR_LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        ready   = 1'b1;
        rd_addr = start_addr;
        if (cmd.valid) begin
          if (cmd.update) begin
            mem_we = 1'b1;
            mem_wa = wr_addr;
            mem_wd = wr_data;
          end
          if (cmd.query) begin
            state_next = (cmd.bad_bound || cmd.empty) ? ST_DONE : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (cur == end_q) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        res.valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  // Single write port, single registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= $signed(mem[rd_addr]);
  end

  // The read data in the scan state always belongs to the entry at cur.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd.valid && cmd.query) begin
      best  <= MAX_FLOOR;
      err   <= cmd.bad_bound;
      cur   <= start_addr;
      end_q <= end_addr;
    end else if (state == ST_SCAN) begin
      if (rd_data > best) begin
        best <= rd_data;
      end
      cur <= cur + AW'(1);
    end
  end

  assign res_max = best;

  `RMQ_ASSERT(a_cmd_only_idle, clk, rst, !cmd.valid || state == ST_IDLE)
  `RMQ_ASSERT(a_scan_in_range, clk, rst, state != ST_SCAN || cur <= end_q)
  `RMQ_ASSERT(a_result_floor, clk, rst, state != ST_DONE || best >= MAX_FLOOR)
  `RMQ_ASSERT_NEXT(a_clear_ends, clk, rst, state == ST_CLEAR && clr == CLR_LAST, state == ST_IDLE)

endmodule

[src/range_max_query_table.sv]
// ---------------------------------------------------------------------------
// range_max_query_table
// Table of signed values with single-entry updates and range maximum queries.
// ---------------------------------------------------------------------------
// After reset the block clears its table memory to zero, one entry a
// cycle, and holds s_axis_tready low while it does so; configuration
// writes are taken throughout. Items are then handled one at a time. An
// update writes its entry on its input beat, and the block stays ready for
// the next beat. A query whose bounds are out of range or reversed goes
// straight from the idle state to the done state, its result enters the
// output register from there, and the next beat is taken after that. A
// query over n entries first passes through the scan state, which reads
// the table memory through its single read port one entry per cycle, and
// then through the done state into the output register. The next item is
// accepted as soon as the previous result has moved into the output
// register, so a result waiting on the master side stalls the block only
// when a second query finishes before the first result has been taken. The
// result is never below -20000, the floor of the running maximum. Bounds
// are 1-based and must lie within the smaller of entries_in_use and
// TABLE_DEPTH: an update outside them is dropped, a query outside them
// returns the floor with range_error set.

module range_max_query_table #(
  parameter int TABLE_DEPTH = rmq_pkg::TABLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration: entries_in_use
  input  logic                           cfg_we,
  input  logic [rmq_pkg::CFG_W-1:0]      cfg_wdata,
  // Input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata from bit 0: position[10:0], new_value[42:11], range_start[53:43],
  // range_end[64:54], zero pad[71:65]
  input  logic [rmq_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: action (0 update, 1 query)
  input  logic                           s_axis_tuser,
  // Output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata from bit 0: max_value[31:0], range_error[32], zero pad[39:33]
  output logic [rmq_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  import rmq_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int XW = (AW > POS_W) ? AW : POS_W;

  logic [CFG_W-1:0] entries_in_use;

  logic [POS_W-1:0] position;
  logic [VAL_W-1:0] new_value;
  logic [POS_W-1:0] range_start;
  logic [POS_W-1:0] range_end;

  logic     pos_ok, start_ok, end_ok;
  logic     accept;
  rmq_cmd_t cmd;
  rmq_res_t res;
  logic [VAL_W-1:0] res_max;
  logic     res_ready;
  logic     eng_ready;

  logic [AW-1:0] wr_addr, start_addr, end_addr;

  // User writes this register only while the block is idle; not enforced.
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= ENTRIES_RESET;
    end else if (cfg_we) begin
      entries_in_use <= cfg_wdata;
    end
  end

  assign position    = s_axis_tdata[10:0];
  assign new_value   = s_axis_tdata[42:11];
  assign range_start = s_axis_tdata[53:43];
  assign range_end   = s_axis_tdata[64:54];

  // A bound must respect both the register and the physical depth.
  assign pos_ok   = bound_ok(position, entries_in_use)
                    && (32'(position) <= 32'(TABLE_DEPTH));
  assign start_ok = bound_ok(range_start, entries_in_use)
                    && (32'(range_start) <= 32'(TABLE_DEPTH));
  assign end_ok   = bound_ok(range_end, entries_in_use)
                    && (32'(range_end) <= 32'(TABLE_DEPTH));

  // Convert 1-based positions to memory addresses.
  assign wr_addr    = AW'(XW'(position) - XW'(1));
  assign start_addr = AW'(XW'(range_start) - XW'(1));
  assign end_addr   = AW'(XW'(range_end) - XW'(1));

  assign s_axis_tready = eng_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    cmd.valid     = accept;
    cmd.update    = (s_axis_tuser == ACT_UPDATE) && pos_ok;
    cmd.query     = (s_axis_tuser == ACT_QUERY);
    cmd.bad_bound = !(start_ok && end_ok);
    cmd.empty     = range_start > range_end;
  end

  rmq_engine #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .wr_data   (new_value),
    .start_addr(start_addr),
    .end_addr  (end_addr),
    .ready     (eng_ready),
    .res       (res),
    .res_max   (res_max),
    .res_ready (res_ready)
  );

  // Output register: it frees the engine while a finished beat waits.
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      m_axis_tdata <= {{(OUT_DATA_W - VAL_W - 1){1'b0}}, res.range_error, res_max};
    end
  end

endmodule
